// ===== design/etg_pkg.sv =====
// shared types and constants for the event triggered send gate
`timescale 1ns / 1ps
package etg_pkg;

  localparam int INDEX_W     = 3;
  localparam int NORM_W      = 32;
  localparam int PASS_W      = 24;
  localparam int VAL_W       = 32;
  localparam int DECAY_W     = 17;
  localparam int WARMUP_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = VAL_W + DECAY_W;
  localparam int ADDR_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DECAY_W-1:0]  DECAY_RESET  = 17'd65536;
  localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd30;
  localparam logic [VAL_W-1:0]    VAL_MAX      = 32'hFFFF_FFFF;
  localparam logic [VAL_W:0]      EVENT_STEP   = 33'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ADAPTIVE_MODE   = 2'd0,
    CFG_DECAY_FACTOR    = 2'd1,
    CFG_FIXED_THRESHOLD = 2'd2,
    CFG_WARMUP_PASSES   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/etg_sample_if.sv =====
// request channel carrying one tensor norm sample
`timescale 1ns / 1ps
interface etg_sample_if;
  import etg_pkg::*;

  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  tensor_index;
  logic [NORM_W-1:0]   current_norm;
  logic [PASS_W-1:0]   pass_number;

  modport source (output valid, tensor_index, current_norm, pass_number, input ready);
  modport sink   (input valid, tensor_index, current_norm, pass_number, output ready);
endinterface

// ===== design/etg_decision_if.sv =====
// request channel carrying one send decision
`timescale 1ns / 1ps
interface etg_decision_if;
  import etg_pkg::*;

  logic              valid;
  logic              ready;
  logic              send_event;
  logic [VAL_W-1:0]  threshold_used;
  logic [VAL_W-1:0]  event_count;

  modport source (output valid, send_event, threshold_used, event_count, input ready);
  modport sink   (input valid, send_event, threshold_used, event_count, output ready);
endinterface

// ===== design/etg_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module etg_div #(
  parameter int DVD_W = 33,
  parameter int DVS_W = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output etg_pkg::div_status_t status,
  output logic [DVD_W-1:0]   quotient
);
  import etg_pkg::*;

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;

  assign rem_sh = {rem, quo[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (!diff[DVS_W+1]) begin
          rem <= diff[DVS_W-1:0];
          quo <= {quo[DVD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DVS_W-1:0];
          quo <= {quo[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
endmodule

// ===== design/etg_mem.sv =====
// per-tensor state memory, registered read, zero until first written
`timescale 1ns / 1ps
module etg_mem #(
  parameter int DEPTH = 8,
  parameter int ROW_W = 152
) (
  input  logic                 clk,
  input  logic                 rst,
  input  etg_pkg::mem_req_t    req,
  input  logic [ROW_W-1:0]     wdata,
  output logic [ROW_W-1:0]     rdata
);
  import etg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ROW_W-1:0] ram [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [ROW_W-1:0] rd_q;
  logic             rd_vld;
  logic [AW-1:0]    addr;

  assign addr = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      ram[addr] <= wdata;
    end
    if (req.rd) begin
      rd_q <= ram[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr) begin
        vld[addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld <= vld[addr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;
endmodule

// ===== design/event_triggered_send_gate.sv =====
// top level: per-tensor send gate sequencer over a state memory
//
//   channel   dir  handshake      payload
//   sample    in   valid/ready    tensor_index, current_norm, pass_number
//   decision  out  valid/ready    send_event, threshold_used, event_count
//   cfg       in   cfg_write      cfg_index, cfg_data
//
// no send: LOOKUP, EVAL, then FINISH registers the decision; IDLE takes the next request after it
// a send adds SLOPE, which waits for the serial slope divide, and SHIFT; a zero gap skips SLOPE
// adaptive mode adds SUM, AVG_GO and AVG_WAIT for the digit-wise history average
// an out-of-range index goes from accept straight to FINISH and writes no state
// the state memory and send total are cleared by rst, no sweep needed
// a stalled decision holds the sequencer in its finish state; one item in flight
`timescale 1ns / 1ps
module event_triggered_send_gate #(
  parameter int NUM_TENSORS = 8,
  parameter int HISTORY_LEN = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [etg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [etg_pkg::CFG_DATA_W-1:0]   cfg_data,
  etg_sample_if.sink                       sample,
  etg_decision_if.source                   decision
);
  import etg_pkg::*;

  localparam int HIST_W   = HISTORY_LEN * VAL_W;
  localparam int PASS_LSB = NORM_W;
  localparam int THR_LSB  = NORM_W + PASS_W;
  localparam int HIST_LSB = THR_LSB + VAL_W;
  localparam int ROW_W    = HIST_LSB + HIST_W;
  localparam int SUM_W    = VAL_W + $clog2(HISTORY_LEN);
  localparam int DVD_W    = VAL_W;
  localparam int HC_W     = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int IDX_CMP_W = ADDR_W + 1;
  localparam int DIG_W    = 4;
  localparam int NDIG     = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int AVG_W    = NDIG * DIG_W;
  localparam int X_W      = HC_W + DIG_W;
  localparam int DC_W     = (NDIG > 1) ? $clog2(NDIG) : 1;

  typedef enum logic [3:0] {
    IDLE, LOOKUP, EVAL, SLOPE, SHIFT, SUM, AVG_GO, AVG_WAIT, FINISH
  } state_t;

  state_t state;

  logic                 adaptive_mode;
  logic [DECAY_W-1:0]   decay_factor;
  logic [VAL_W-1:0]     fixed_threshold;
  logic [WARMUP_W-1:0]  warmup_passes;

  logic [INDEX_W-1:0]   idx_q;
  logic [NORM_W-1:0]    norm_q;
  logic [PASS_W-1:0]    pass_q;
  logic                 ignore_q;
  logic [NORM_W-1:0]    old_norm_q;
  logic [PASS_W-1:0]    old_pass_q;
  logic [VAL_W-1:0]     dist_q;
  logic [PASS_W-1:0]    gap_q;
  logic [PROD_W-1:0]    prod_q;
  logic [VAL_W-1:0]     thr_q;
  logic [VAL_W-1:0]     thr_new_q;
  logic                 event_q;
  logic [VAL_W-1:0]     slope_q;
  logic [VAL_W-1:0]     hist_q [HISTORY_LEN];
  logic [SUM_W-1:0]     sum_q;
  logic [HC_W-1:0]      cnt;
  logic [VAL_W-1:0]     send_total;
  logic [AVG_W-1:0]     avg_sh;
  logic [HC_W-1:0]      avg_rem;
  logic [DC_W-1:0]      dig_cnt;

  mem_req_t             mem_req;
  logic [ROW_W-1:0]     mem_wdata;
  logic [ROW_W-1:0]     mem_rdata;
  logic [NORM_W-1:0]    rd_norm;
  logic [PASS_W-1:0]    rd_pass;
  logic [VAL_W-1:0]     rd_thr;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dividend;
  logic [PASS_W-1:0]    div_divisor;
  div_status_t          div_status;
  logic [DVD_W-1:0]     div_quotient;

  logic                 accept;
  logic                 in_range;
  logic [VAL_W-1:0]     thr_eval;
  logic                 event_eval;
  logic                 fin_go;
  logic [VAL_W:0]       total_sum;
  logic [VAL_W-1:0]     total_next;
  logic [X_W-1:0]       avg_x;
  logic [DIG_W-1:0]     avg_q;
  logic [X_W-1:0]       avg_r;
  logic [AVG_W-1:0]     avg_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_mode   <= 1'b0;
      decay_factor    <= DECAY_RESET;
      fixed_threshold <= '0;
      warmup_passes   <= WARMUP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ADAPTIVE_MODE:   adaptive_mode   <= cfg_data[0];
        CFG_DECAY_FACTOR:    decay_factor    <= cfg_data[DECAY_W-1:0];
        CFG_FIXED_THRESHOLD: fixed_threshold <= cfg_data[VAL_W-1:0];
        CFG_WARMUP_PASSES:   warmup_passes   <= cfg_data[WARMUP_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample.ready = (state == IDLE);
  assign accept       = sample.valid && sample.ready;
  assign in_range     = IDX_CMP_W'(sample.tensor_index) < IDX_CMP_W'(NUM_TENSORS);
  assign fin_go       = !decision.valid || decision.ready;

  assign rd_norm = mem_rdata[NORM_W-1:0];
  assign rd_pass = mem_rdata[PASS_LSB +: PASS_W];
  assign rd_thr  = mem_rdata[THR_LSB +: VAL_W];

  // threshold and event rule
  always_comb begin
    if (adaptive_mode) begin
      thr_eval = (|prod_q[PROD_W-1:VAL_W+FRAC_W]) ? VAL_MAX : prod_q[VAL_W+FRAC_W-1:FRAC_W];
    end else begin
      thr_eval = fixed_threshold;
    end
    event_eval = (dist_q >= thr_eval) || (pass_q < PASS_W'(warmup_passes));
  end

  assign total_sum  = {1'b0, send_total} + EVENT_STEP;
  assign total_next = !event_q ? send_total : (total_sum[VAL_W] ? VAL_MAX : total_sum[VAL_W-1:0]);

  // slope divider
  always_comb begin
    div_start    = 1'b0;
    div_dividend = dist_q;
    div_divisor  = gap_q;
    case (state)
      EVAL: begin
        div_start = event_eval && (gap_q != '0);
      end
      default: ;
    endcase
  end

  // history average: one quotient digit per cycle against multiples of HISTORY_LEN
  always_comb begin
    avg_x = {avg_rem, avg_sh[AVG_W-1 -: DIG_W]};
    avg_q = '0;
    for (int k = 1; k < (1 << DIG_W); k++) begin
      if (avg_x >= X_W'(k * HISTORY_LEN)) begin
        avg_q = DIG_W'(k);
      end
    end
    avg_r    = avg_x - X_W'(avg_q) * X_W'(HISTORY_LEN);
    avg_next = {avg_sh[AVG_W-DIG_W-1:0], avg_q};
  end

  // memory access
  always_comb begin
    mem_req.rd   = accept && in_range;
    mem_req.wr   = (state == FINISH) && fin_go && !ignore_q;
    mem_req.addr = (state == FINISH) ? ADDR_W'(idx_q) : ADDR_W'(sample.tensor_index);
    mem_wdata[NORM_W-1:0]          = event_q ? norm_q : old_norm_q;
    mem_wdata[PASS_LSB +: PASS_W]  = event_q ? pass_q : old_pass_q;
    mem_wdata[THR_LSB +: VAL_W]    = thr_new_q;
    for (int j = 0; j < HISTORY_LEN; j++) begin
      mem_wdata[HIST_LSB + VAL_W*j +: VAL_W] = hist_q[j];
    end
  end

  etg_mem #(
    .DEPTH (NUM_TENSORS),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  etg_div #(
    .DVD_W (DVD_W),
    .DVS_W (PASS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      send_total     <= '0;
      decision.valid <= 1'b0;
    end else begin
      if (decision.valid && decision.ready && state != FINISH) begin
        decision.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            idx_q     <= sample.tensor_index;
            norm_q    <= sample.current_norm;
            pass_q    <= sample.pass_number;
            ignore_q  <= !in_range;
            event_q   <= 1'b0;
            thr_q     <= '0;
            state     <= in_range ? LOOKUP : FINISH;
          end
        end
        LOOKUP: begin
          old_norm_q <= rd_norm;
          old_pass_q <= rd_pass;
          dist_q     <= (norm_q >= rd_norm) ? norm_q - rd_norm : rd_norm - norm_q;
          gap_q      <= pass_q - rd_pass;
          prod_q     <= PROD_W'(rd_thr) * PROD_W'(decay_factor);
          for (int j = 0; j < HISTORY_LEN; j++) begin
            hist_q[j] <= mem_rdata[HIST_LSB + VAL_W*j +: VAL_W];
          end
          state <= EVAL;
        end
        EVAL: begin
          thr_q     <= thr_eval;
          thr_new_q <= thr_eval;
          event_q   <= event_eval;
          slope_q   <= VAL_MAX;
          if (!event_eval) begin
            state <= FINISH;
          end else if (gap_q == '0) begin
            state <= SHIFT;
          end else begin
            state <= SLOPE;
          end
        end
        SLOPE: begin
          if (div_status.done) begin
            slope_q <= div_quotient[VAL_W-1:0];
            state   <= SHIFT;
          end
        end
        SHIFT: begin
          for (int j = 0; j < HISTORY_LEN - 1; j++) begin
            hist_q[j] <= hist_q[j+1];
          end
          hist_q[HISTORY_LEN-1] <= slope_q;
          sum_q <= '0;
          cnt   <= '0;
          state <= adaptive_mode ? SUM : FINISH;
        end
        SUM: begin
          sum_q <= sum_q + SUM_W'(hist_q[cnt]);
          cnt   <= cnt + 1'b1;
          if (cnt == HC_W'(HISTORY_LEN - 1)) begin
            state <= AVG_GO;
          end
        end
        AVG_GO: begin
          avg_sh  <= AVG_W'(sum_q);
          avg_rem <= '0;
          dig_cnt <= '0;
          state   <= AVG_WAIT;
        end
        AVG_WAIT: begin
          avg_sh  <= avg_next;
          avg_rem <= avg_r[HC_W-1:0];
          dig_cnt <= dig_cnt + 1'b1;
          if (dig_cnt == DC_W'(NDIG - 1)) begin
            // average never exceeds the largest entry
            thr_new_q <= avg_next[VAL_W-1:0];
            state     <= FINISH;
          end
        end
        FINISH: begin
          if (fin_go) begin
            send_total              <= total_next;
            decision.valid          <= 1'b1;
            decision.send_event     <= event_q;
            decision.threshold_used <= thr_q;
            decision.event_count    <= total_next;
            state                   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // send total only grows
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> send_total >= $past(send_total))
    else $error("send total decreased");

  // send total moves in steps of two until it saturates
  a_total_even: assert property (@(posedge clk) disable iff (rst)
    send_total[0] == 1'b0 || send_total == VAL_MAX)
    else $error("send total odd below saturation");

  // every state write-back comes with a decision
  a_write_gives_result: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr |=> decision.valid)
    else $error("write-back without decision");

  // divider is never restarted while running
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider restarted while busy");

endmodule

// ===== tb/tb_event_triggered_send_gate.sv =====
// self-checking testbench for the event triggered send gate
`timescale 1ns / 1ps
module tb_event_triggered_send_gate;
  import etg_pkg::*;

  localparam int NUM_T      = 1 << INDEX_W;
  localparam int HIST_DEPTH = 2;
  localparam int SETTLE     = 100;
  localparam int DRAIN_MAX  = 100000;
  localparam int PRINT_MAX  = 50;
  localparam logic [CFG_DATA_W-1:0] DECAY_TOP = 32'h0001_FFFF;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [NORM_W-1:0]  norm;
    logic [PASS_W-1:0]  pass_no;
  } sample_t;

  typedef struct packed {
    logic             send;
    logic [VAL_W-1:0] thr;
    logic [VAL_W-1:0] total;
  } decision_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  etg_sample_if   sample_ch ();
  etg_decision_if decision_ch ();

  event_triggered_send_gate #(
    .NUM_TENSORS (NUM_T),
    .HISTORY_LEN (HIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .decision  (decision_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic                cur_adaptive = 1'b0;
  logic [DECAY_W-1:0]  cur_decay    = DECAY_RESET;
  logic [VAL_W-1:0]    cur_fixed    = '0;
  logic [WARMUP_W-1:0] cur_warmup   = WARMUP_RESET;

  // per-tensor gate state
  logic [VAL_W-1:0]  sent_norm  [NUM_T]             = '{default: '0};
  logic [PASS_W-1:0] sent_pass  [NUM_T]             = '{default: '0};
  logic [VAL_W-1:0]  slope_hist [NUM_T][HIST_DEPTH] = '{default: '{default: '0}};
  logic [VAL_W-1:0]  thr_store  [NUM_T]             = '{default: '0};
  logic [VAL_W-1:0]  sends_total = '0;

  sample_t   pending_samples [$];
  decision_t expected_decisions [$];
  sample_t   next_sample;

  int  errors = 0;
  int  samples_taken = 0;
  int  decisions_checked = 0;
  int  sends_predicted = 0;
  int  settings_applied = 0;
  int  send_gap = 0;
  int  recv_hold = 0;
  bit  steady = 1'b0;

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    if (errors < PRINT_MAX)
      $display("mismatch %s at %0t: got %h want %h", what, $time, got, want);
    errors++;
  endtask

  function automatic void gate_decide(input sample_t s);
    logic [VAL_W-1:0]  norm_gap;
    logic [VAL_W-1:0]  thr;
    logic [VAL_W-1:0]  slope;
    logic [PASS_W-1:0] gap;
    logic [63:0]       prod;
    logic [63:0]       sum;
    logic [VAL_W:0]    bumped;
    logic              fire;
    decision_t         outcome;
    int                t;
    int                j;
    t = s.index;
    norm_gap = s.norm >= sent_norm[t] ? s.norm - sent_norm[t] : sent_norm[t] - s.norm;
    gap = s.pass_no - sent_pass[t];
    if (cur_adaptive) begin
      prod = (64'(thr_store[t]) * 64'(cur_decay)) >> FRAC_W;
      thr = prod > 64'(VAL_MAX) ? VAL_MAX : prod[VAL_W-1:0];
    end else begin
      thr = cur_fixed;
    end
    thr_store[t] = thr;
    fire = (norm_gap >= thr) || (s.pass_no < PASS_W'(cur_warmup));
    if (fire) begin
      // zero pass gap gives the maximum slope
      slope = gap == '0 ? VAL_MAX : norm_gap / VAL_W'(gap);
      sum = '0;
      for (j = 0; j < HIST_DEPTH - 1; j++) begin
        slope_hist[t][j] = slope_hist[t][j + 1];
        sum += 64'(slope_hist[t][j]);
      end
      slope_hist[t][HIST_DEPTH - 1] = slope;
      sum += 64'(slope);
      sum = sum / HIST_DEPTH;
      if (cur_adaptive)
        thr_store[t] = sum > 64'(VAL_MAX) ? VAL_MAX : sum[VAL_W-1:0];
      sent_norm[t] = s.norm;
      sent_pass[t] = s.pass_no;
      bumped = {1'b0, sends_total} + EVENT_STEP;
      sends_total = bumped[VAL_W] ? VAL_MAX : bumped[VAL_W-1:0];
      sends_predicted++;
    end
    outcome = '{fire, thr, sends_total};
    expected_decisions.insert(expected_decisions.size(), outcome);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.tensor_index <= '0;
      sample_ch.current_norm <= '0;
      sample_ch.pass_number <= '0;
      send_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        gate_decide('{sample_ch.tensor_index, sample_ch.current_norm,
                      sample_ch.pass_number});
        samples_taken++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          sample_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          next_sample = pending_samples.pop_front();
          sample_ch.tensor_index <= next_sample.index;
          sample_ch.current_norm <= next_sample.norm;
          sample_ch.pass_number <= next_sample.pass_no;
          sample_ch.valid <= 1'b1;
          if (!steady && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 9);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // decision monitor
  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      decision_ch.ready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (decision_ch.valid && decision_ch.ready) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("decision with no request pending", decision_ch.threshold_used, '0);
        end else begin
          want = expected_decisions.pop_front();
          if (decision_ch.send_event !== want.send)
            report_mismatch("send_event", VAL_W'(decision_ch.send_event), VAL_W'(want.send));
          if (decision_ch.threshold_used !== want.thr)
            report_mismatch("threshold_used", decision_ch.threshold_used, want.thr);
          if (decision_ch.event_count !== want.total)
            report_mismatch("event_count", decision_ch.event_count, want.total);
          decisions_checked++;
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        decision_ch.ready <= 1'b0;
      end else begin
        decision_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0)
          recv_hold <= $urandom_range(1, 9);
      end
    end
  end

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      CFG_ADAPTIVE_MODE:   cur_adaptive = value[0];
      CFG_DECAY_FACTOR:    cur_decay = value[DECAY_W-1:0];
      CFG_FIXED_THRESHOLD: cur_fixed = value;
      CFG_WARMUP_PASSES:   cur_warmup = value[WARMUP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic adaptive, input logic [CFG_DATA_W-1:0] decay,
                           input logic [CFG_DATA_W-1:0] fixed_thr,
                           input logic [CFG_DATA_W-1:0] warmup);
    write_reg(CFG_ADAPTIVE_MODE, CFG_DATA_W'(adaptive));
    write_reg(CFG_DECAY_FACTOR, decay);
    write_reg(CFG_FIXED_THRESHOLD, fixed_thr);
    write_reg(CFG_WARMUP_PASSES, warmup);
    settings_applied++;
  endtask

  function automatic void add_sample(input int index, input logic [NORM_W-1:0] norm,
                                     input logic [PASS_W-1:0] pass_no);
    sample_t s;
    s = '{INDEX_W'(index), norm, pass_no};
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_samples.size() != 0 || sample_ch.valid ||
            expected_decisions.size() != 0) && waited < DRAIN_MAX) begin
      @(negedge clk);
      waited++;
    end
  endtask

  function automatic logic [NORM_W-1:0] nudge_norm(input logic [NORM_W-1:0] norm,
                                                   input int scale);
    logic [NORM_W-1:0] delta;
    delta = $urandom_range(0, (1 << scale) - 1);
    return $urandom_range(0, 1) ? norm + delta : norm - delta;
  endfunction

  // drifting norms per tensor over advancing passes, mixed with noise
  task automatic training_phase(input int count);
    logic [NORM_W-1:0]     norm_now [NUM_T];
    logic [PASS_W-1:0]     pass_now;
    logic [CFG_DATA_W-1:0] decay;
    logic [CFG_DATA_W-1:0] fixed_thr;
    logic [CFG_DATA_W-1:0] warmup;
    int                    scale;
    int                    n;
    int                    t;
    scale = $urandom_range(4, 24);
    case ($urandom_range(0, 3))
      0: decay = '0;
      1: decay = DECAY_TOP;
      2: decay = CFG_DATA_W'(DECAY_RESET);
      default: decay = $urandom_range(49152, 65535);
    endcase
    case ($urandom_range(0, 3))
      0: fixed_thr = '0;
      1: fixed_thr = VAL_MAX;
      default: fixed_thr = $urandom_range(0, 1 << (scale + 1));
    endcase
    case ($urandom_range(0, 3))
      0: warmup = '0;
      1: warmup = 32'h0000_FFFF;
      default: warmup = $urandom_range(0, 64);
    endcase
    write_all(1'($urandom_range(0, 1)), decay, fixed_thr, warmup);
    case ($urandom_range(0, 2))
      0: pass_now = PASS_W'($urandom_range(0, 40));
      1: pass_now = 24'hFF_FFFF - PASS_W'($urandom_range(0, 200));
      default: pass_now = PASS_W'($urandom_range(0, 24'hFF_FFFF));
    endcase
    for (t = 0; t < NUM_T; t++)
      norm_now[t] = $urandom;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 3) begin
        add_sample(int'($urandom_range(0, NUM_T - 1)), $urandom,
                   PASS_W'($urandom_range(0, 24'hFF_FFFF)));
        n++;
      end else begin
        pass_now += PASS_W'($urandom_range(0, 3));
        for (t = 0; t < NUM_T && n < count; t++) begin
          if ($urandom_range(0, 7) != 0) begin
            norm_now[t] = nudge_norm(norm_now[t], scale);
            add_sample(t, norm_now[t], pass_now);
            n++;
          end
        end
      end
    end
    drain();
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: zero fixed threshold, default warm-up
    settings_applied++;
    add_sample(0, '0, '0);
    add_sample(NUM_T - 1, VAL_MAX, 24'hFF_FFFF);
    add_sample(NUM_T - 1, '0, 24'd5);
    add_sample(3, 32'h1234_5678, 24'd100);
    add_sample(3, 32'h1234_5678, 24'd100);
    add_sample(5, 32'h8000_0000, 24'd31);
    drain();

    // adaptive, top decay: threshold climbs to saturation
    write_all(1'b1, DECAY_TOP, '0, '0);
    add_sample(1, '0, 24'd10);
    add_sample(1, '0, 24'd10);
    add_sample(1, '0, 24'd10);
    add_sample(1, '0, 24'd11);
    add_sample(1, VAL_MAX, 24'd12);
    add_sample(2, 32'h0001_0000, 24'd40);
    drain();

    // constant top threshold, widest warm-up
    write_all(1'b0, CFG_DATA_W'(DECAY_RESET), VAL_MAX, 32'h0000_FFFF);
    add_sample(4, '0, 24'h00_FFFE);
    add_sample(4, 32'd5, 24'h00_FFFF);
    add_sample(4, VAL_MAX, 24'h02_0000);
    add_sample(6, VAL_MAX, 24'd1000);
    drain();

    // adaptive with zero decay
    write_all(1'b1, '0, 32'h0000_8000, '0);
    add_sample(1, '0, 24'd20);
    add_sample(1, 32'd1, 24'd21);
    add_sample(0, 32'hFFFF_0000, 24'd22);
    drain();

    for (p = 0; p < 8; p++) begin
      if (p == 7)
        steady = 1'b1;
      training_phase(180);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (expected_decisions.size() != 0)
      report_mismatch("decisions never delivered", VAL_W'(expected_decisions.size()), '0);
    $display("covered %0d requests over %0d register settings", samples_taken, settings_applied);
    $display("checked %0d decisions, %0d of them sends", decisions_checked, sends_predicted);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
